[design/aalu_pkg.sv]
`timescale 1ns / 1ps

package aalu_pkg;

   typedef enum logic [4:0] {
      ACT_ADD = 5'd0,
      ACT_ADC = 5'd1,
      ACT_SUB = 5'd2,
      ACT_SBB = 5'd3,
      ACT_ANA = 5'd4,
      ACT_ORA = 5'd5,
      ACT_XRA = 5'd6,
      ACT_CMP = 5'd7,
      ACT_INR = 5'd8,
      ACT_DCR = 5'd9,
      ACT_INX = 5'd10,
      ACT_DCX = 5'd11,
      ACT_DAA = 5'd12,
      ACT_RLC = 5'd13,
      ACT_RRC = 5'd14,
      ACT_RAL = 5'd15,
      ACT_RAR = 5'd16,
      ACT_DAD = 5'd17
   } action_type;

   localparam int FLAG_S_BIT  = 7;
   localparam int FLAG_Z_BIT  = 6;
   localparam int FLAG_AC_BIT = 4;
   localparam int FLAG_P_BIT  = 2;
   localparam int FLAG_CY_BIT = 0;

   localparam logic [7:0] DAA_LO_FIX = 8'h06;
   localparam logic [7:0] DAA_HI_FIX = 8'h60;
   localparam logic [3:0] BCD_MAX    = 4'h9;

   typedef struct packed {
      logic [7:0]  acc;
      logic [7:0]  flags;
      logic [15:0] hl;
   } alu_state_type;

   typedef struct packed {
      logic [4:0]  action;
      logic [7:0]  operand;
      logic [15:0] pair_operand;
   } alu_item_type;

   typedef struct packed {
      logic [7:0]  accumulator;
      logic [7:0]  flag_byte;
      logic [7:0]  byte_result;
      logic [15:0] pair_result;
   } alu_result_type;

   function automatic logic [7:0] szp_flags(input logic [7:0] v, input logic ac,
                                            input logic cy);
      logic [7:0] f;
      f = 8'h00;
      f[FLAG_S_BIT]  = v[7];
      f[FLAG_Z_BIT]  = (v == 8'h00);
      f[FLAG_AC_BIT] = ac;
      f[FLAG_P_BIT]  = ~(^v);
      f[FLAG_CY_BIT] = cy;
      return f;
   endfunction

endpackage

[design/accumulator_alu_with_flags_top.sv]
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  tuser: action; tdata: operand, pair_operand
// rsp       out        rsp_tvalid/rsp_tready  tdata: accumulator, flag_byte, byte_result,
//                                              pair_result
//
// one word per cycle sustained while rsp_tready holds; a word passes the input register, then the result register
// the alu works in one pass from the input register into the result register, and
// the accumulator, flags and hl update in the same cycle, so the next word sees them
// reset clears the accumulator, flags, hl and both valid bits
// a stall on rsp holds the result; one more word is taken into the input register

module accumulator_alu_with_flags_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [4:0]  req_tuser,   // action
   input  logic [23:0] req_tdata,   // operand, pair_operand
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // accumulator, flag_byte, byte_result, pair_result
);
   import aalu_pkg::*;

   logic           in_valid_ff;
   alu_item_type   in_item_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   alu_result_type out_ff;
   alu_state_type  state_ff;
   alu_state_type  state_in;
   alu_result_type result;
   logic           advance;
   logic           in_valid_in;

   aalu_core u_core (
      .state      (state_ff),
      .item       (in_item_ff),
      .state_next (state_in),
      .result     (result)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.action       <= req_tuser;
         in_item_ff.operand      <= req_tdata[7:0];
         in_item_ff.pair_operand <= req_tdata[23:8];
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.pair_result, out_ff.byte_result, out_ff.flag_byte,
                        out_ff.accumulator};

endmodule

[design/aalu_core.sv]
`timescale 1ns / 1ps

module aalu_core (
   input  aalu_pkg::alu_state_type  state,
   input  aalu_pkg::alu_item_type   item,
   output aalu_pkg::alu_state_type  state_next,
   output aalu_pkg::alu_result_type result
);
   import aalu_pkg::*;

   logic [7:0] a;
   logic [7:0] b;
   logic       cy;
   logic       ac;
   logic [7:0] add_b;
   logic       add_cin;
   logic [8:0] add_sum;
   logic [4:0] add_nib;
   logic [7:0] inr_val;
   logic [7:0] dcr_val;
   logic [3:0] lo;
   logic [3:0] hi;
   logic [7:0] daa_corr;
   logic       daa_cy;
   logic [7:0] daa_val;
   logic [4:0] daa_nib;
   logic [16:0] dad_sum;
   logic [7:0] logic_val;
   logic       is_sub;

   always_comb begin
      a  = state.acc;
      b  = item.operand;
      cy = state.flags[FLAG_CY_BIT];
      ac = state.flags[FLAG_AC_BIT];

      // shared adder for add, subtract and compare
      is_sub = (action_type'(item.action) == ACT_SUB) || (action_type'(item.action) == ACT_SBB)
            || (action_type'(item.action) == ACT_CMP);
      add_b = is_sub ? ~b : b;
      case (action_type'(item.action))
         ACT_ADD: add_cin = 1'b0;
         ACT_ADC: add_cin = cy;
         ACT_SBB: add_cin = ~cy;
         default: add_cin = is_sub;
      endcase
      add_sum = {1'b0, a} + {1'b0, add_b} + {8'h00, add_cin};
      add_nib = {1'b0, a[3:0]} + {1'b0, add_b[3:0]} + {4'h0, add_cin};

      inr_val = b + 8'd1;
      dcr_val = b - 8'd1;

      // decimal adjust
      lo = a[3:0];
      hi = a[7:4];
      daa_corr = 8'h00;
      daa_cy   = cy;
      if ((lo > BCD_MAX) || ac) begin
         daa_corr = daa_corr | DAA_LO_FIX;
      end
      if ((hi > BCD_MAX) || cy || ((hi >= BCD_MAX) && (lo > BCD_MAX))) begin
         daa_corr = daa_corr | DAA_HI_FIX;
         daa_cy   = 1'b1;
      end
      daa_val = a + daa_corr;
      daa_nib = {1'b0, lo} + {1'b0, daa_corr[3:0]};

      dad_sum = {1'b0, state.hl} + {1'b0, item.pair_operand};

      case (action_type'(item.action))
         ACT_ANA: logic_val = a & b;
         ACT_ORA: logic_val = a | b;
         default: logic_val = a ^ b;
      endcase

      state_next = state;
      result.byte_result = 8'h00;
      result.pair_result = 16'h0000;

      case (action_type'(item.action))
         ACT_ADD, ACT_ADC: begin
            state_next.acc   = add_sum[7:0];
            state_next.flags = szp_flags(add_sum[7:0], add_nib[4], add_sum[8]);
         end
         ACT_SUB, ACT_SBB: begin
            state_next.acc   = add_sum[7:0];
            state_next.flags = szp_flags(add_sum[7:0], add_nib[4], ~add_sum[8]);
         end
         ACT_CMP: begin
            state_next.flags = szp_flags(add_sum[7:0], add_nib[4], ~add_sum[8]);
         end
         ACT_ANA: begin
            state_next.acc   = logic_val;
            state_next.flags = szp_flags(logic_val, 1'b1, 1'b0);
         end
         ACT_ORA, ACT_XRA: begin
            state_next.acc   = logic_val;
            state_next.flags = szp_flags(logic_val, 1'b0, 1'b0);
         end
         ACT_INR: begin
            result.byte_result = inr_val;
            state_next.flags   = szp_flags(inr_val, b[3:0] == 4'hf, cy);
         end
         ACT_DCR: begin
            result.byte_result = dcr_val;
            state_next.flags   = szp_flags(dcr_val, b[3:0] != 4'h0, cy);
         end
         ACT_INX: begin
            result.pair_result = item.pair_operand + 16'd1;
         end
         ACT_DCX: begin
            result.pair_result = item.pair_operand - 16'd1;
         end
         ACT_DAA: begin
            state_next.acc   = daa_val;
            state_next.flags = szp_flags(daa_val, daa_nib[4], daa_cy);
         end
         ACT_RLC: begin
            state_next.acc = {a[6:0], a[7]};
            state_next.flags[FLAG_CY_BIT] = a[7];
         end
         ACT_RRC: begin
            state_next.acc = {a[0], a[7:1]};
            state_next.flags[FLAG_CY_BIT] = a[0];
         end
         ACT_RAL: begin
            state_next.acc = {a[6:0], cy};
            state_next.flags[FLAG_CY_BIT] = a[7];
         end
         ACT_RAR: begin
            state_next.acc = {cy, a[7:1]};
            state_next.flags[FLAG_CY_BIT] = a[0];
         end
         ACT_DAD: begin
            state_next.hl = dad_sum[15:0];
            state_next.flags[FLAG_CY_BIT] = dad_sum[16];
            result.pair_result = dad_sum[15:0];
         end
         default: begin
         end
      endcase

      result.accumulator = state_next.acc;
      result.flag_byte   = state_next.flags;
   end

endmodule
